/* rtl/tpcc_pkg.sv */
// shared types, constants and codes of the touch panel coordinate conditioner
`default_nettype none

package tpcc_pkg;

    // field and parameter defaults
    localparam int FIELD_W      = 12;
    localparam int SMP_MAX      = 3;
    localparam int SMP_CNT_DEF  = 3;
    localparam int ADC_BITS_DEF = 12;

    // per-lane sum of up to three scaled samples
    localparam int SUM_W = FIELD_W + 2;

    // serial divider: one quotient bit per cycle, quotient never exceeds the screen size
    localparam int DIV_STEPS = FIELD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // divide by three as multiply by a rounded-up reciprocal, exact for sums below 2**15
    localparam int RECIP_SH = 16;
    localparam logic [RECIP_SH-1:0] RECIP3 = RECIP_SH'(((1 << RECIP_SH) + 2) / 3);
    localparam int PROD3_W = SUM_W + RECIP_SH;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION    = 3'd6;

    // configuration reset values
    localparam logic [FIELD_W-1:0] RST_RAW_LOW  = 12'd0;
    localparam logic [FIELD_W-1:0] RST_RAW_HIGH = 12'd4095;
    localparam logic [FIELD_W-1:0] RST_SCREEN_W = 12'd320;
    localparam logic [FIELD_W-1:0] RST_SCREEN_H = 12'd240;

    // rotation codes
    localparam logic [1:0] ROT_NONE    = 2'd0;
    localparam logic [1:0] ROT_QUARTER = 2'd1;
    localparam logic [1:0] ROT_HALF    = 2'd2;
    localparam logic [1:0] ROT_THREE   = 2'd3;

    // event kinds
    localparam logic EVT_PRESS   = 1'b0;
    localparam logic EVT_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_AVG,
        ST_ROT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic step;
        logic acc;
    } t_lane_ctl;

endpackage

`default_nettype wire

/* rtl/tpcc_if.sv */
// valid/ready channel interfaces for polls and touch events
`default_nettype none

interface tpcc_in_if;
    import tpcc_pkg::*;
    logic               valid;
    logic               ready;
    logic               pen_down;
    logic [FIELD_W-1:0] sample_x0;
    logic [FIELD_W-1:0] sample_x1;
    logic [FIELD_W-1:0] sample_x2;
    logic [FIELD_W-1:0] sample_y0;
    logic [FIELD_W-1:0] sample_y1;
    logic [FIELD_W-1:0] sample_y2;

    modport source (
        output valid, pen_down, sample_x0, sample_x1, sample_x2,
               sample_y0, sample_y1, sample_y2,
        input  ready
    );
    modport sink (
        input  valid, pen_down, sample_x0, sample_x1, sample_x2,
               sample_y0, sample_y1, sample_y2,
        output ready
    );
endinterface

interface tpcc_out_if;
    import tpcc_pkg::*;
    logic               valid;
    logic               ready;
    logic               event_kind;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;

    modport source (output valid, event_kind, pos_x, pos_y, input ready);
    modport sink (input valid, event_kind, pos_x, pos_y, output ready);
endinterface

`default_nettype wire

/* rtl/tpcc_lane.sv */
// one axis: scale a raw sample by multiply and bit-serial divide, then accumulate
`default_nettype none

module tpcc_lane
    import tpcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_lane_ctl          i_ctl,
    input  wire logic [FIELD_W-1:0] i_raw,
    input  wire logic [FIELD_W-1:0] i_lo,
    input  wire logic [FIELD_W-1:0] i_hi,
    input  wire logic [FIELD_W-1:0] i_size,
    output logic      [SUM_W-1:0]   o_sum
);

    logic [FIELD_W-1:0]   span;
    logic [FIELD_W-1:0]   delta;
    logic [2*FIELD_W-1:0] prod;
    logic [FIELD_W:0]     trial;
    logic [FIELD_W:0]     diff;
    logic                 qbit;
    logic [FIELD_W-1:0]   rem_nxt;

    // remainder in the upper half, dividend bits then quotient bits in the lower half
    logic [2*FIELD_W-1:0] r_rq;
    logic [SUM_W-1:0]     r_sum;

    assign span  = i_hi - i_lo;
    assign delta = i_hi - i_raw;
    assign prod  = {{FIELD_W{1'b0}}, delta} * {{FIELD_W{1'b0}}, i_size};

    assign trial   = r_rq[2*FIELD_W-1:FIELD_W-1];
    assign diff    = trial - {1'b0, span};
    assign qbit    = ~diff[FIELD_W];
    assign rem_nxt = qbit ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rq <= prod;
        end else if (i_ctl.step) begin
            r_rq <= {rem_nxt, r_rq[FIELD_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + SUM_W'(r_rq[FIELD_W-1:0]);
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

/* rtl/touch_panel_coordinate_conditioner.sv */
// touch panel coordinate conditioner: polls in, press and release events out
//
// i_req carries one poll per transfer: the pen-down level and three raw X and
// three raw Y samples. o_rsp carries one event: a press with screen
// coordinates, or a release with both coordinates zero. Configuration is a
// plain write port (i_cfg_we, i_cfg_idx, i_cfg_data), written by the user
// only while idle; the block itself does not enforce this. A poll that
// starts a touch with all samples inside their windows runs the samples
// one at a time through a multiplier and a bit-serial divider per axis
// (both axes side by side): each sample is loaded, divided bit-serially to
// a 12-bit quotient and accumulated, then the average is taken, rotated and
// handed off as a press. A release goes from its poll straight to the
// hand-off; polls that cause no event leave the block idle.
// The finished event sits in an output register, so the next poll is taken
// while a stalled receiver holds it; a second event waits in a pending
// register until the output frees up. Reset clears the touch flag, drops
// any event in flight and loads the default configuration.
`default_nettype none

module touch_panel_coordinate_conditioner
    import tpcc_pkg::*;
#(
    parameter int SAMPLE_COUNT = SMP_CNT_DEF,
    parameter int ADC_BITS     = ADC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tpcc_in_if.sink                   i_req,
    tpcc_out_if.source                o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FIELD_W-1:0]   i_cfg_data
);

    localparam int NUM_SMP   = (SAMPLE_COUNT > SMP_MAX) ? SMP_MAX :
                               ((SAMPLE_COUNT < 1) ? 1 : SAMPLE_COUNT);
    localparam int SMP_CNT_W = (NUM_SMP > 1) ? $clog2(NUM_SMP) : 1;
    localparam logic [SMP_CNT_W-1:0] SMP_LAST = SMP_CNT_W'(NUM_SMP - 1);
    localparam int RAW_W     = (ADC_BITS < FIELD_W) ? ADC_BITS : FIELD_W;
    localparam logic [FIELD_W-1:0] RAW_MASK = FIELD_W'((1 << RAW_W) - 1);

    function automatic logic in_window(input logic [FIELD_W-1:0] raw,
                                       input logic [FIELD_W-1:0] lo,
                                       input logic [FIELD_W-1:0] hi);
        in_window = (hi > lo) && (raw >= lo) && (raw <= hi);
    endfunction

    // zero when wrapped below zero or not below the limit
    function automatic logic [FIELD_W-1:0] clip(input logic [FIELD_W:0]   v,
                                                input logic [FIELD_W-1:0] lim);
        if (v[FIELD_W] || (v[FIELD_W-1:0] >= lim)) begin
            clip = '0;
        end else begin
            clip = v[FIELD_W-1:0];
        end
    endfunction

    // configuration
    logic [FIELD_W-1:0] r_x_lo, r_x_hi, r_y_lo, r_y_hi, r_width, r_height;
    logic [1:0]         r_rot;

    // control
    t_state                r_state, n_state;
    logic                  r_touch;
    logic [DIV_CNT_W-1:0]  r_bit_cnt;
    logic [SMP_CNT_W-1:0]  r_smp_cnt;
    logic                  r_out_valid;

    // payload
    logic [FIELD_W-1:0] r_smp_x [NUM_SMP];
    logic [FIELD_W-1:0] r_smp_y [NUM_SMP];
    logic [FIELD_W-1:0] r_avg_x, r_avg_y;
    logic               r_pend_kind;
    logic [FIELD_W-1:0] r_pend_x, r_pend_y;
    logic               r_out_kind;
    logic [FIELD_W-1:0] r_out_x, r_out_y;

    logic [FIELD_W-1:0] in_x [SMP_MAX];
    logic [FIELD_W-1:0] in_y [SMP_MAX];
    logic               all_ok;
    logic               in_xfer;
    logic               out_free;
    t_lane_ctl          lane_ctl;
    logic [SUM_W-1:0]   sum_x, sum_y;
    logic [PROD3_W-1:0] p3_x, p3_y;
    logic [FIELD_W-1:0] avg_x, avg_y;
    logic [FIELD_W-1:0] rot_x, rot_y;

    assign in_x[0] = i_req.sample_x0;
    assign in_x[1] = i_req.sample_x1;
    assign in_x[2] = i_req.sample_x2;
    assign in_y[0] = i_req.sample_y0;
    assign in_y[1] = i_req.sample_y1;
    assign in_y[2] = i_req.sample_y2;

    always_comb begin
        all_ok = 1'b1;
        for (int i = 0; i < NUM_SMP; i++) begin
            if (!in_window(in_x[i] & RAW_MASK, r_x_lo, r_x_hi) ||
                !in_window(in_y[i] & RAW_MASK, r_y_lo, r_y_hi)) begin
                all_ok = 1'b0;
            end
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_xfer     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // next state and lane control
    always_comb begin
        n_state  = r_state;
        lane_ctl = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (!i_req.pen_down) begin
                        if (r_touch) begin
                            n_state = ST_EMIT;
                        end
                    end else if (!r_touch && all_ok) begin
                        lane_ctl.clr = 1'b1;
                        n_state      = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                lane_ctl.load = 1'b1;
                n_state       = ST_DIV;
            end
            ST_DIV: begin
                lane_ctl.step = 1'b1;
                if (r_bit_cnt == DIV_LAST) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                lane_ctl.acc = 1'b1;
                n_state      = (r_smp_cnt == SMP_LAST) ? ST_AVG : ST_MUL;
            end
            ST_AVG:  n_state = ST_ROT;
            ST_ROT:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    tpcc_lane u_lane_x (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_raw  (r_smp_x[0]),
        .i_lo   (r_x_lo),
        .i_hi   (r_x_hi),
        .i_size (r_width),
        .o_sum  (sum_x)
    );

    tpcc_lane u_lane_y (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_raw  (r_smp_y[0]),
        .i_lo   (r_y_lo),
        .i_hi   (r_y_hi),
        .i_size (r_height),
        .o_sum  (sum_y)
    );

    // average over the sample count
    assign p3_x = PROD3_W'(sum_x) * PROD3_W'(RECIP3);
    assign p3_y = PROD3_W'(sum_y) * PROD3_W'(RECIP3);

    always_comb begin
        if (NUM_SMP == 3) begin
            avg_x = p3_x[FIELD_W+RECIP_SH-1:RECIP_SH];
            avg_y = p3_y[FIELD_W+RECIP_SH-1:RECIP_SH];
        end else if (NUM_SMP == 2) begin
            avg_x = sum_x[FIELD_W:1];
            avg_y = sum_y[FIELD_W:1];
        end else begin
            avg_x = sum_x[FIELD_W-1:0];
            avg_y = sum_y[FIELD_W-1:0];
        end
    end

    // rotation, with clipping to the screen for the rotated settings
    always_comb begin
        case (r_rot)
            ROT_QUARTER: begin
                rot_x = clip({1'b0, r_avg_y}, r_height);
                rot_y = clip({1'b0, r_width} - {1'b0, r_avg_x}, r_width);
            end
            ROT_HALF: begin
                rot_x = clip({1'b0, r_width} - {1'b0, r_avg_x}, r_width);
                rot_y = clip({1'b0, r_height} - {1'b0, r_avg_y}, r_height);
            end
            ROT_THREE: begin
                rot_x = clip({1'b0, r_height} - {1'b0, r_avg_y}, r_height);
                rot_y = clip({1'b0, r_avg_x}, r_width);
            end
            default: begin
                rot_x = r_avg_x;
                rot_y = r_avg_y;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lo      <= RST_RAW_LOW;
            r_x_hi      <= RST_RAW_HIGH;
            r_y_lo      <= RST_RAW_LOW;
            r_y_hi      <= RST_RAW_HIGH;
            r_width     <= RST_SCREEN_W;
            r_height    <= RST_SCREEN_H;
            r_rot       <= ROT_NONE;
            r_touch     <= 1'b0;
            r_bit_cnt   <= '0;
            r_smp_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RAW_X_LOW:  r_x_lo   <= i_cfg_data & RAW_MASK;
                    CFG_RAW_X_HIGH: r_x_hi   <= i_cfg_data & RAW_MASK;
                    CFG_RAW_Y_LOW:  r_y_lo   <= i_cfg_data & RAW_MASK;
                    CFG_RAW_Y_HIGH: r_y_hi   <= i_cfg_data & RAW_MASK;
                    CFG_SCREEN_W:   r_width  <= i_cfg_data;
                    CFG_SCREEN_H:   r_height <= i_cfg_data;
                    CFG_ROTATION:   r_rot    <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_touch   <= i_req.pen_down;
                r_smp_cnt <= '0;
            end
            if (r_state == ST_MUL) begin
                r_bit_cnt <= '0;
            end else if (r_state == ST_DIV) begin
                r_bit_cnt <= r_bit_cnt + 1'b1;
            end
            if (r_state == ST_ACC) begin
                r_smp_cnt <= r_smp_cnt + 1'b1;
            end
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int i = 0; i < NUM_SMP; i++) begin
                r_smp_x[i] <= in_x[i] & RAW_MASK;
                r_smp_y[i] <= in_y[i] & RAW_MASK;
            end
            r_pend_kind <= EVT_RELEASE;
            r_pend_x    <= '0;
            r_pend_y    <= '0;
        end
        // next sample moves to the lane tap
        if (r_state == ST_ACC) begin
            for (int i = 0; i < NUM_SMP - 1; i++) begin
                r_smp_x[i] <= r_smp_x[i+1];
                r_smp_y[i] <= r_smp_y[i+1];
            end
        end
        if (r_state == ST_AVG) begin
            r_avg_x <= avg_x;
            r_avg_y <= avg_y;
        end
        if (r_state == ST_ROT) begin
            r_pend_kind <= EVT_PRESS;
            r_pend_x    <= rot_x;
            r_pend_y    <= rot_y;
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out_kind <= r_pend_kind;
            r_out_x    <= r_pend_x;
            r_out_y    <= r_pend_y;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.event_kind = r_out_kind;
    assign o_rsp.pos_x      = r_out_x;
    assign o_rsp.pos_y      = r_out_y;

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.event_kind == EVT_RELEASE) |->
            (o_rsp.pos_x == '0 && o_rsp.pos_y == '0))
        else $error("release carries nonzero coordinates");

    a_pen_up_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_req.pen_down) |=> !r_touch)
        else $error("touch flag kept after pen up");

    a_pen_down_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_req.pen_down) |=> r_touch)
        else $error("touch flag not set after pen down");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_bit_cnt <= DIV_LAST && r_smp_cnt <= SMP_LAST))
        else $error("divider step or sample count out of range");

    a_press_needs_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROT) |-> r_touch)
        else $error("press computed without an active touch");

endmodule

`default_nettype wire

/* bench/tpcc_event_checker.sv */
// scoreboard for the touch panel conditioner: mirrors the registers, predicts and compares events
`default_nettype none

module tpcc_event_checker
    import tpcc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tpcc_in_if                        req,
    tpcc_out_if                       rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FIELD_W-1:0]   i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending,
    output int                        o_presses,
    output int                        o_releases
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
    } t_touch_evt;

    logic [FIELD_W-1:0] x_low, x_high, y_low, y_high, scr_w, scr_h;
    logic [1:0]         rot;
    logic               touching;
    t_touch_evt         events_due[$];

    // raw sample to screen units, zero return when outside its window
    function automatic bit scale_raw(input logic [FIELD_W-1:0] raw, lo, hi, size,
                                     output int unsigned val);
        val = 0;
        if (hi <= lo || raw < lo || raw > hi)
            return 1'b0;
        val = ((32'(hi) - 32'(raw)) * 32'(size)) / (32'(hi) - 32'(lo));
        return 1'b1;
    endfunction

    // one poll against the touch flag; returns 1 when it yields an event
    function automatic bit condition_poll(input logic pen,
                                          input logic [FIELD_W-1:0] xs[SMP_MAX],
                                          input logic [FIELD_W-1:0] ys[SMP_MAX],
                                          output t_touch_evt evt);
        int unsigned sum_x, sum_y, vx, vy, ax, ay, nx, ny, w, h;
        bit          in_window;
        evt = '{EVT_RELEASE, '0, '0};
        if (!pen) begin
            if (!touching)
                return 1'b0;
            touching = 1'b0;
            return 1'b1;
        end
        if (touching)
            return 1'b0;
        touching = 1'b1;
        in_window = 1'b1;
        sum_x = 0;
        sum_y = 0;
        for (int i = 0; i < SMP_MAX; i++) begin
            if (!scale_raw(xs[i], x_low, x_high, scr_w, vx))
                in_window = 1'b0;
            if (!scale_raw(ys[i], y_low, y_high, scr_h, vy))
                in_window = 1'b0;
            sum_x += vx;
            sum_y += vy;
        end
        if (!in_window)
            return 1'b0;
        ax = sum_x / SMP_MAX;
        ay = sum_y / SMP_MAX;
        w = scr_w;
        h = scr_h;
        nx = ax;
        ny = ay;
        // rotated coordinates at or past their limit fold to zero
        case (rot)
            ROT_QUARTER: begin
                nx = ay;
                ny = w - ax;
                if (nx >= h) nx = 0;
                if (ny >= w) ny = 0;
            end
            ROT_HALF: begin
                nx = w - ax;
                ny = h - ay;
                if (nx >= w) nx = 0;
                if (ny >= h) ny = 0;
            end
            ROT_THREE: begin
                nx = h - ay;
                ny = ax;
                if (nx >= h) nx = 0;
                if (ny >= w) ny = 0;
            end
            default: ;
        endcase
        evt = '{EVT_PRESS, FIELD_W'(nx), FIELD_W'(ny)};
        return 1'b1;
    endfunction

    task automatic note_mismatch(input bit had_want, input t_touch_evt want,
                                 input t_touch_evt got);
        if (o_mismatches < 10) begin
            if (had_want)
                $display("event mismatch: want kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
                         want.kind, want.pos_x, want.pos_y, got.kind, got.pos_x, got.pos_y);
            else
                $display("unexpected event: kind %0d x %0d y %0d",
                         got.kind, got.pos_x, got.pos_y);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_touch_evt         want, got;
        logic [FIELD_W-1:0] xs[SMP_MAX], ys[SMP_MAX];
        if (!i_rst_n) begin
            x_low = RST_RAW_LOW;
            x_high = RST_RAW_HIGH;
            y_low = RST_RAW_LOW;
            y_high = RST_RAW_HIGH;
            scr_w = RST_SCREEN_W;
            scr_h = RST_SCREEN_H;
            rot = ROT_NONE;
            touching = 1'b0;
            events_due.delete();
            o_mismatches = 0;
            o_presses = 0;
            o_releases = 0;
        end else begin
            // results first: an event never leaves in the cycle its poll arrives
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.event_kind, rsp.pos_x, rsp.pos_y};
                if (got.kind == EVT_PRESS)
                    o_presses++;
                else
                    o_releases++;
                if (events_due.size() == 0) begin
                    note_mismatch(1'b0, got, got);
                end else begin
                    want = events_due.pop_front();
                    if (got.kind !== want.kind || got.pos_x !== want.pos_x
                            || got.pos_y !== want.pos_y)
                        note_mismatch(1'b1, want, got);
                end
            end
            if (req.valid && req.ready) begin
                xs = '{req.sample_x0, req.sample_x1, req.sample_x2};
                ys = '{req.sample_y0, req.sample_y1, req.sample_y2};
                if (condition_poll(req.pen_down, xs, ys, want))
                    events_due.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RAW_X_LOW:  x_low = i_cfg_data;
                    CFG_RAW_X_HIGH: x_high = i_cfg_data;
                    CFG_RAW_Y_LOW:  y_low = i_cfg_data;
                    CFG_RAW_Y_HIGH: y_high = i_cfg_data;
                    CFG_SCREEN_W:   scr_w = i_cfg_data;
                    CFG_SCREEN_H:   scr_h = i_cfg_data;
                    CFG_ROTATION:   rot = i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
        o_pending = events_due.size();
    end

endmodule

`default_nettype wire

/* bench/tb_touch_panel_coordinate_conditioner.sv */
// top of the touch panel conditioner bench: clock, reset, polls, registers and verdict
`default_nettype none

module tb_touch_panel_coordinate_conditioner;
    timeunit 1ns;
    timeprecision 1ps;
    import tpcc_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RST_CYCLES     = 12;
    localparam int IDLE_LIMIT     = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 60;
    localparam int FIXED_PHASES   = 7;
    localparam int N_PHASES       = 15;
    localparam int FIXED_TOUCHES  = 20;
    localparam int RANDOM_TOUCHES = 30;

    typedef struct packed {
        logic [FIELD_W-1:0] x_low;
        logic [FIELD_W-1:0] x_high;
        logic [FIELD_W-1:0] y_low;
        logic [FIELD_W-1:0] y_high;
        logic [FIELD_W-1:0] width;
        logic [FIELD_W-1:0] height;
        logic [1:0]         rot;
    } t_panel_cfg;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [FIELD_W-1:0]   cfg_data;

    int         mismatches, pending, presses, releases;
    int         polls_sent, touches_run, idle_cycles;
    bit         sender_quiet, receiver_quiet, hold_pending;
    t_panel_cfg cur_cfg;

    tpcc_in_if  req_if();
    tpcc_out_if rsp_if();

    touch_panel_coordinate_conditioner dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tpcc_event_checker u_event_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .req          (req_if),
        .rsp          (rsp_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_presses    (presses),
        .o_releases   (releases)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic send_poll(input logic pen, input logic [FIELD_W-1:0] x0, x1, x2,
                             input logic [FIELD_W-1:0] y0, y1, y2);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.pen_down = pen;
        req_if.sample_x0 = x0;
        req_if.sample_x1 = x1;
        req_if.sample_x2 = x2;
        req_if.sample_y0 = y0;
        req_if.sample_y1 = y1;
        req_if.sample_y2 = y2;
        req_if.valid = 1'b1;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        @(negedge clk);
        polls_sent++;
    endtask

    task automatic send_noise(input logic pen);
        send_poll(pen, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                  FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    // press at one raw point, then lift
    task automatic tap_at(input logic [FIELD_W-1:0] xv, yv);
        send_poll(1'b1, xv, xv, xv, yv, yv, yv);
        send_noise(1'b0);
        touches_run++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
        cfg_idx = idx;
        cfg_data = val;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_panel_cfg(input t_panel_cfg c);
        write_reg(CFG_RAW_X_LOW, c.x_low);
        write_reg(CFG_RAW_X_HIGH, c.x_high);
        write_reg(CFG_RAW_Y_LOW, c.y_low);
        write_reg(CFG_RAW_Y_HIGH, c.y_high);
        write_reg(CFG_SCREEN_W, c.width);
        write_reg(CFG_SCREEN_H, c.height);
        write_reg(CFG_ROTATION, FIELD_W'(c.rot));
        cur_cfg = c;
    endtask

    // stop offering until every event is out, then let a silent poll finish
    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] raw_sample(input logic [FIELD_W-1:0] lo, hi);
        int pick;
        pick = $urandom_range(0, 99);
        if (hi > lo && pick < 95)
            return FIELD_W'($urandom_range(hi, lo));
        if (pick < 98)
            return FIELD_W'($urandom);
        return pick[0] ? lo - 1'b1 : hi + 1'b1;
    endfunction

    // window edges and just outside them
    task automatic edge_taps();
        tap_at(cur_cfg.x_low, cur_cfg.y_low);
        tap_at(cur_cfg.x_high, cur_cfg.y_high);
        tap_at(cur_cfg.x_low, cur_cfg.y_high);
        tap_at(cur_cfg.x_low - 1'b1, cur_cfg.y_high + 1'b1);
        tap_at(cur_cfg.x_high + 1'b1, cur_cfg.y_low);
    endtask

    // an occasional idle poll, press, held polls, lift, with the odd stray poll
    task automatic random_touch();
        logic [FIELD_W-1:0] xs[3], ys[3];
        int                 holds;
        if ($urandom_range(0, 3) == 0)
            send_noise(1'b0);
        for (int i = 0; i < 3; i++) begin
            xs[i] = raw_sample(cur_cfg.x_low, cur_cfg.x_high);
            ys[i] = raw_sample(cur_cfg.y_low, cur_cfg.y_high);
        end
        send_poll(1'b1, xs[0], xs[1], xs[2], ys[0], ys[1], ys[2]);
        holds = $urandom_range(0, 2);
        repeat (holds) send_noise(1'b1);
        send_noise(1'b0);
        if ($urandom_range(0, 19) == 0)
            send_noise(1'($urandom_range(0, 1)));
        touches_run++;
    endtask

    function automatic t_panel_cfg phase_cfg(input int p);
        t_panel_cfg c;
        case (p)
            1: c = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095, ROT_QUARTER};
            2: c = '{12'd100, 12'd3900, 12'd200, 12'd3800, 12'd800, 12'd480, ROT_HALF};
            3: c = '{12'd2000, 12'd2001, 12'd4094, 12'd4095, 12'd1, 12'd1, ROT_THREE};
            // empty windows: high equal to low on x, below it on y
            4: c = '{12'd3000, 12'd3000, 12'd4095, 12'd0, 12'd320, 12'd240, ROT_NONE};
            5: c = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, ROT_QUARTER};
            6: c = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095, ROT_NONE};
            default: begin
                c.x_low = FIELD_W'($urandom_range(0, 2047));
                c.x_high = FIELD_W'($urandom_range(4095, c.x_low + 1));
                c.y_low = FIELD_W'($urandom_range(0, 2047));
                c.y_high = FIELD_W'($urandom_range(4095, c.y_low + 1));
                c.width = FIELD_W'($urandom_range(1, 4095));
                c.height = FIELD_W'($urandom_range(1, 4095));
                c.rot = 2'($urandom_range(0, 3));
            end
        endcase
        return c;
    endfunction

    // receiving side, with one long hold-off on request
    initial begin : rsp_side
        int stall;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_pending) begin
                rsp_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_pending = 1'b0;
            end
            stall = receiver_quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                rsp_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
            do @(posedge clk); while (rsp_if.valid !== 1'b1);
            @(negedge clk);
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int n_touches;
        req_if.valid = 1'b0;
        req_if.pen_down = 1'b0;
        req_if.sample_x0 = '0;
        req_if.sample_x1 = '0;
        req_if.sample_x2 = '0;
        req_if.sample_y0 = '0;
        req_if.sample_y1 = '0;
        req_if.sample_y2 = '0;
        cfg_we = 1'b0;
        cfg_idx = CFG_RAW_X_LOW;
        cfg_data = '0;
        rst_n = 1'b0;
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        hold_pending = 1'b0;
        polls_sent = 0;
        touches_run = 0;
        repeat (RST_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // defaults after reset: lift with no touch, bit patterns, a held press
        cur_cfg = '{RST_RAW_LOW, RST_RAW_HIGH, RST_RAW_LOW, RST_RAW_HIGH,
                    RST_SCREEN_W, RST_SCREEN_H, ROT_NONE};
        send_poll(1'b0, '0, '0, '0, '0, '0, '0);
        send_poll(1'b1, 12'hAAA, 12'h555, 12'hFFF, 12'h555, 12'hAAA, 12'h000);
        send_poll(1'b1, 12'h555, 12'hAAA, 12'h000, 12'hAAA, 12'h555, 12'hFFF);
        send_poll(1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        touches_run++;
        edge_taps();
        wait_drained();

        for (int p = 1; p < N_PHASES; p++) begin
            load_panel_cfg(phase_cfg(p));
            sender_quiet = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
            if (p == 2)
                hold_pending = 1'b1;
            edge_taps();
            n_touches = (p < FIXED_PHASES) ? FIXED_TOUCHES : RANDOM_TOUCHES;
            for (int i = 0; i < n_touches; i++) begin
                random_touch();
                if (p == FIXED_PHASES + 1 && i == n_touches / 2)
                    wait_drained();
            end
            wait_drained();
        end

        $display("covered %0d polls in %0d touches over %0d panel settings", polls_sent,
                 touches_run, N_PHASES);
        $display("checked %0d presses and %0d releases, all rotations and edge windows",
                 presses, releases);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/tpcc_pkg.sv
rtl/tpcc_if.sv
rtl/tpcc_lane.sv
rtl/touch_panel_coordinate_conditioner.sv
bench/tpcc_event_checker.sv
bench/tb_touch_panel_coordinate_conditioner.sv
